// File: rtl/ksrk_pkg.sv
// ----------------------------------------------------------------------------
// ksrk_pkg
// Shared types, sizes, status codes and key normalization for the key stack.
// ----------------------------------------------------------------------------
package ksrk_pkg;

    localparam int DEPTH     = 16;
    localparam int KEY_BYTES = 7;
    localparam int KEY_W     = 56;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = ADDR_W + 1;

    localparam logic       CMD_PUSH     = 1'b0;
    localparam logic       CMD_REMOVE   = 1'b1;

    localparam logic [2:0] ST_PUSHED    = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    typedef struct packed {
        logic             cmd;
        logic [KEY_W-1:0] key_value;
    } t_in_word;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] entry_count;
    } t_out_word;

    typedef struct packed {
        logic             valid;
        logic [2:0]       status;
        logic [CNT_W-1:0] count;
    } t_done;

    // Clear every byte from the first zero byte upward and beyond KEY_BYTES.
    function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] res;
        logic             ended;
        res   = '0;
        ended = 1'b0;
        for (int b = 0; b < KEY_W / 8; b++) begin
            if (b >= KEY_BYTES || raw[8*b +: 8] == 8'h00) begin
                ended = 1'b1;
            end
            if (!ended) begin
                res[8*b +: 8] = raw[8*b +: 8];
            end
        end
        return res;
    endfunction

endpackage

// File: rtl/ksrk_mem.sv
// ----------------------------------------------------------------------------
// ksrk_mem
// Key storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ksrk_mem (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [ksrk_pkg::ADDR_W-1:0] i_wr_addr,
    input  logic [ksrk_pkg::KEY_W-1:0]  i_wr_data,
    input  logic                       i_rd_en,
    input  logic [ksrk_pkg::ADDR_W-1:0] i_rd_addr,
    output logic [ksrk_pkg::KEY_W-1:0]  o_rd_data
);

    logic [ksrk_pkg::KEY_W-1:0] r_mem [ksrk_pkg::DEPTH];
    logic [ksrk_pkg::KEY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/ksrk_ctl.sv
// ----------------------------------------------------------------------------
// ksrk_ctl
// Command sequencer: push, top-down search with one shared comparator, and
// gap closing by moving entries down one slot at a time.
// ----------------------------------------------------------------------------
module ksrk_ctl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  ksrk_pkg::t_in_word         i_word,
    output ksrk_pkg::t_done            o_done
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_SRD  = 3'd3;
    localparam logic [2:0] S_SWR  = 3'd4;

    logic [2:0]                   r_state, n_state;
    logic [ksrk_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [ksrk_pkg::ADDR_W-1:0]  r_idx, n_idx;
    logic [ksrk_pkg::KEY_W-1:0]   r_key, n_key;
    logic [ksrk_pkg::KEY_W-1:0]   in_key;
    logic [ksrk_pkg::KEY_W-1:0]   rd_data;
    logic                         wr_en;
    logic [ksrk_pkg::ADDR_W-1:0]  wr_addr;
    logic [ksrk_pkg::KEY_W-1:0]   wr_data;
    logic                         rd_en;
    logic [ksrk_pkg::ADDR_W-1:0]  rd_addr;
    logic [ksrk_pkg::CNT_W-1:0]   idx_ext;
    logic [ksrk_pkg::CNT_W-1:0]   idx_p1;
    logic [ksrk_pkg::CNT_W-1:0]   idx_p2;
    logic                         key_hit;

    ksrk_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign in_key  = ksrk_pkg::norm_key(i_word.key_value);
    assign idx_ext = {1'b0, r_idx};
    assign idx_p1  = idx_ext + ksrk_pkg::CNT_W'(1);
    assign idx_p2  = idx_ext + ksrk_pkg::CNT_W'(2);
    assign key_hit = (rd_data == r_key);

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_idx        = r_idx;
        n_key        = r_key;
        wr_en        = 1'b0;
        wr_addr      = r_idx;
        wr_data      = rd_data;
        rd_en        = 1'b0;
        rd_addr      = r_idx;
        o_done       = '0;
        o_done.count = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_key = in_key;
                    if (i_word.cmd == ksrk_pkg::CMD_PUSH) begin
                        o_done.valid = 1'b1;
                        if (r_cnt == ksrk_pkg::CNT_W'(ksrk_pkg::DEPTH)) begin
                            o_done.status = ksrk_pkg::ST_FULL;
                        end else begin
                            wr_en         = 1'b1;
                            wr_addr       = r_cnt[ksrk_pkg::ADDR_W-1:0];
                            wr_data       = in_key;
                            n_cnt         = r_cnt + ksrk_pkg::CNT_W'(1);
                            o_done.status = ksrk_pkg::ST_PUSHED;
                            o_done.count  = n_cnt;
                        end
                    end else if (r_cnt == '0) begin
                        o_done.valid  = 1'b1;
                        o_done.status = ksrk_pkg::ST_EMPTY;
                    end else begin
                        n_idx   = ksrk_pkg::ADDR_W'(r_cnt - ksrk_pkg::CNT_W'(1));
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                rd_en   = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (key_hit) begin
                    if (idx_p1 < r_cnt) begin
                        n_state = S_SRD;
                    end else begin
                        n_cnt         = r_cnt - ksrk_pkg::CNT_W'(1);
                        o_done.valid  = 1'b1;
                        o_done.status = ksrk_pkg::ST_REMOVED;
                        o_done.count  = n_cnt;
                        n_state       = S_IDLE;
                    end
                end else if (r_idx == '0) begin
                    o_done.valid  = 1'b1;
                    o_done.status = ksrk_pkg::ST_NOT_FOUND;
                    n_state       = S_IDLE;
                end else begin
                    n_idx   = r_idx - ksrk_pkg::ADDR_W'(1);
                    n_state = S_RD;
                end
            end
            S_SRD: begin
                rd_en   = 1'b1;
                rd_addr = idx_p1[ksrk_pkg::ADDR_W-1:0];
                n_state = S_SWR;
            end
            S_SWR: begin
                wr_en = 1'b1;
                if (idx_p2 < r_cnt) begin
                    n_idx   = idx_p1[ksrk_pkg::ADDR_W-1:0];
                    n_state = S_SRD;
                end else begin
                    n_cnt         = r_cnt - ksrk_pkg::CNT_W'(1);
                    o_done.valid  = 1'b1;
                    o_done.status = ksrk_pkg::ST_REMOVED;
                    o_done.count  = n_cnt;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_idx <= n_idx;
        r_key <= n_key;
    end

endmodule

// File: rtl/key_stack_remove_by_key_core.sv
// ----------------------------------------------------------------------------
// key_stack_remove_by_key_core
// Bounded stack of 7-byte keys with push and remove of the topmost match.
// ----------------------------------------------------------------------------
// Push, full and empty answer in the cycle after the input word is taken.
// Remove: a read and a compare state per entry searched from the top, plus a read
// and a write state per entry moved down (registered-read memory, one comparator).
// Throughput: one command at a time; the next word is taken once the result
// word has left the output register.
// Reset (synchronous, active low) empties the stack; key memory is not cleared.
module key_stack_remove_by_key_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ksrk_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ksrk_pkg::t_out_word  o_out_word
);

    logic                 r_busy, n_busy;
    logic                 r_out_valid, n_out_valid;
    ksrk_pkg::t_out_word  r_out_word, n_out_word;
    ksrk_pkg::t_done      done;
    logic                 in_acc;

    // Hold off new words while a command runs or a result word waits.
    assign o_in_stall = r_busy | r_out_valid;
    assign in_acc     = i_in_valid & ~o_in_stall;

    ksrk_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc),
        .i_word  (i_in_word),
        .o_done  (done)
    );

    always_comb begin
        n_busy      = (r_busy | in_acc) & ~done.valid;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        // Drop the result word once the far side takes it.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        // Capture the finished result into the output register.
        if (done.valid) begin
            n_out_valid            = 1'b1;
            n_out_word.status      = done.status;
            n_out_word.entry_count = 5'(done.count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // A result only comes from a command that is running or just taken.
    a_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done.valid |-> (r_busy || in_acc))
        else $error("result without a command in flight");

    // No result may overwrite a pending result word.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !done.valid)
        else $error("result overran the output register");

    // Reported count never exceeds the stack depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done.valid |-> (done.count <= ksrk_pkg::CNT_W'(ksrk_pkg::DEPTH)))
        else $error("entry count beyond depth");

endmodule
